// ===== hdl/tle_pkg.sv =====
// Shared constants and types of the terminal line editor.
`default_nettype none
package tle_pkg;
	localparam int LINE_MAX   = 64;
	localparam int HIST_DEPTH = 8;
	localparam int LEN_W      = 7;
	localparam int COL_W      = 6;
	localparam int SLOT_W     = 3;
	localparam int USED_W     = 4;
	localparam int HIST_AW    = SLOT_W + COL_W;
	localparam int HIST_WORDS = HIST_DEPTH * LINE_MAX;

	localparam logic [LEN_W-1:0]  LINE_MAX_L = LEN_W'(LINE_MAX);
	localparam logic [USED_W-1:0] HIST_FULL  = USED_W'(HIST_DEPTH);

	localparam logic [1:0] KIND_UPDATE = 2'd0;
	localparam logic [1:0] KIND_CHAR   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_ESC   = 8'h1B;
	localparam logic [7:0] KEY_SPACE = 8'h20;
	localparam logic [7:0] KEY_DEL   = 8'h7F;
	localparam logic [7:0] KEY_LBRK  = 8'h5B;
	localparam logic [7:0] KEY_TILDE = 8'h7E;
	localparam logic [7:0] KEY_UP    = 8'h41;
	localparam logic [7:0] KEY_DOWN  = 8'h42;
	localparam logic [7:0] KEY_RIGHT = 8'h43;
	localparam logic [7:0] KEY_LEFT  = 8'h44;
	localparam logic [7:0] KEY_HOME  = 8'h48;
	localparam logic [7:0] KEY_END   = 8'h46;
	localparam logic [7:0] KEY_THREE = 8'h33;
	localparam logic [7:0] KEY_FIVE  = 8'h35;
	localparam logic [7:0] KEY_SIX   = 8'h36;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESC,
		PH_CSI,
		PH_DELK,
		PH_PAGE
	} phase_t;

	typedef enum logic [1:0] {
		MEM_EDIT,
		MEM_STASH,
		MEM_HIST
	} mem_sel_t;

	typedef enum logic [1:0] {
		POST_LOAD,
		POST_SETLEN,
		POST_EMIT
	} post_t;
endpackage
`default_nettype wire

// ===== hdl/tle_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/terminal_line_editor_with_history_core.sv =====
// Top level of the terminal line editor with command history.
// Usage:
//   s_* carries one keyboard byte per word (s_tdata). Bytes 0x80 and up are
//   dropped. m_* carries results: tdata = kind, char_out, line_length,
//   cursor_col; tlast marks the final result of a keystroke.
//   s_tready is high only while the sequencer is idle. Escape prefixes and
//   ignored bytes leave the sequencer idle. Insert and delete move the
//   characters after the cursor one at a time, history recall and store copy
//   a line one character at a time, and Enter compares the line with the
//   newest entry when the lengths match, then emits it one character per
//   result word. Each line RAM has a single read port and is walked one
//   character per step.
//   The output word sits in a register; the sequencer waits there while the
//   receiver stalls, and the next byte is taken once the final result of the
//   last one is loaded. Reset clears the control state; line and history
//   RAMs are not cleared and are only read where written.
`default_nettype none
module terminal_line_editor_with_history_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // key_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,  // kind[1:0], char_out[9:2], line_length[16:10], cursor_col[23:17]
	output logic             m_tlast   // last
);
	localparam int LW = tle_pkg::LEN_W;
	localparam int CW = tle_pkg::COL_W;
	localparam int SW = tle_pkg::SLOT_W;
	localparam int UW = tle_pkg::USED_W;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_UP,
		ST_DOWN,
		ST_LOAD,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_ENT_SAVE,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_ENT_STORE,
		ST_EMIT_PREP,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t            state_q;
	tle_pkg::phase_t   ph_q;
	tle_pkg::mem_sel_t src_q, dst_q;
	tle_pkg::post_t    post_q;
	logic [LW-1:0]     len_q, cur_q, idx_q, cnt_q, nline_q, stash_len_q;
	logic              stash_v_q;
	logic [UW-1:0]     used_q, browse_q;
	logic [SW-1:0]     oldest_q, slot_q;
	logic [LW-1:0]     hlen_q [tle_pkg::HIST_DEPTH];
	logic [7:0]        key_q;
	logic              out_v_q, out_last_q;
	logic [1:0]        out_kind_q;
	logic [7:0]        out_char_q;
	logic [LW-1:0]     out_len_q, out_cur_q;

	logic [CW-1:0]     edit_raddr, edit_waddr, stash_addr;
	logic [7:0]        edit_rdata, stash_rdata, hist_rdata, edit_wdata, src_data;
	logic              edit_we, stash_we, hist_we;
	logic [tle_pkg::HIST_AW-1:0] hist_addr, hist_waddr;
	logic              out_free, out_load;
	logic [LW-1:0]     idx_m1, idx_p1;
	logic [UW-1:0]     b_dn, b_up;

	assign out_free   = !out_v_q || m_tready;
	assign out_load   = out_free && (state_q == ST_UPDATE || state_q == ST_EMIT_WR ||
	                                 (state_q == ST_EMIT_PREP && nline_q == '0));
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_v_q;
	assign m_tdata    = {out_cur_q, out_len_q, out_char_q, out_kind_q};
	assign m_tlast    = out_last_q;
	assign idx_m1     = idx_q - LW'(1);
	assign idx_p1     = idx_q + LW'(1);
	assign b_dn       = browse_q - UW'(1);
	assign b_up       = browse_q + UW'(1);
	assign stash_addr = idx_q[CW-1:0];
	assign hist_addr  = {slot_q, idx_q[CW-1:0]};
	assign hist_waddr = hist_addr;

	always_comb begin
		unique case (state_q)
			ST_INS_RD, ST_INS_WR: edit_raddr = idx_m1[CW-1:0];
			ST_DEL_RD, ST_DEL_WR: edit_raddr = idx_p1[CW-1:0];
			default:              edit_raddr = idx_q[CW-1:0];
		endcase
	end

	always_comb begin
		unique case (src_q)
			tle_pkg::MEM_STASH: src_data = stash_rdata;
			tle_pkg::MEM_HIST:  src_data = hist_rdata;
			default:            src_data = edit_rdata;
		endcase
	end

	always_comb begin
		edit_we    = 1'b0;
		edit_waddr = idx_q[CW-1:0];
		edit_wdata = edit_rdata;
		stash_we   = (state_q == ST_COPY_WR) && (dst_q == tle_pkg::MEM_STASH);
		hist_we    = (state_q == ST_COPY_WR) && (dst_q == tle_pkg::MEM_HIST);
		unique case (state_q)
			ST_INS_WR, ST_DEL_WR: edit_we = 1'b1;
			ST_INS_PUT: begin
				edit_we    = 1'b1;
				edit_waddr = cur_q[CW-1:0];
				edit_wdata = key_q;
			end
			ST_COPY_WR: begin
				edit_we    = (dst_q == tle_pkg::MEM_EDIT);
				edit_wdata = src_data;
			end
			default: edit_we = 1'b0;
		endcase
	end

	tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::LINE_MAX)) u_edit (
		.clk(clk), .we(edit_we), .waddr(edit_waddr), .wdata(edit_wdata),
		.raddr(edit_raddr), .rdata(edit_rdata)
	);

	tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::LINE_MAX)) u_stash (
		.clk(clk), .we(stash_we), .waddr(stash_addr), .wdata(src_data),
		.raddr(stash_addr), .rdata(stash_rdata)
	);

	tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::HIST_WORDS)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(src_data),
		.raddr(hist_addr), .rdata(hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= tle_pkg::PH_NORMAL;
			len_q       <= '0;
			cur_q       <= '0;
			stash_len_q <= '0;
			stash_v_q   <= 1'b0;
			used_q      <= '0;
			oldest_q    <= '0;
			browse_q    <= '0;
			out_v_q     <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			nline_q     <= '0;
			slot_q      <= '0;
			src_q       <= tle_pkg::MEM_EDIT;
			dst_q       <= tle_pkg::MEM_EDIT;
			post_q      <= tle_pkg::POST_SETLEN;
		end else begin
			if (out_v_q && m_tready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && !s_tdata[7]) begin
						key_q <= s_tdata;
						unique case (ph_q)
							tle_pkg::PH_ESC: begin
								if (s_tdata == tle_pkg::KEY_LBRK) begin
									ph_q <= tle_pkg::PH_CSI;
								end else begin
									ph_q    <= tle_pkg::PH_NORMAL;
									state_q <= ST_UPDATE;
								end
							end
							tle_pkg::PH_CSI: begin
								ph_q <= tle_pkg::PH_NORMAL;
								priority if (s_tdata == tle_pkg::KEY_UP) begin
									state_q <= ST_UP;
								end else if (s_tdata == tle_pkg::KEY_DOWN) begin
									state_q <= ST_DOWN;
								end else if (s_tdata == tle_pkg::KEY_RIGHT) begin
									if (cur_q < len_q) cur_q <= cur_q + LW'(1);
									state_q <= ST_UPDATE;
								end else if (s_tdata == tle_pkg::KEY_LEFT) begin
									if (cur_q != '0) cur_q <= cur_q - LW'(1);
									state_q <= ST_UPDATE;
								end else if (s_tdata == tle_pkg::KEY_HOME) begin
									cur_q   <= '0;
									state_q <= ST_UPDATE;
								end else if (s_tdata == tle_pkg::KEY_END) begin
									cur_q   <= len_q;
									state_q <= ST_UPDATE;
								end else if (s_tdata == tle_pkg::KEY_THREE) begin
									ph_q    <= tle_pkg::PH_DELK;
									state_q <= ST_IDLE;
								end else if (s_tdata == tle_pkg::KEY_FIVE ||
								             s_tdata == tle_pkg::KEY_SIX) begin
									ph_q    <= tle_pkg::PH_PAGE;
									state_q <= ST_IDLE;
								end else begin
									state_q <= ST_UPDATE;
								end
							end
							tle_pkg::PH_DELK: begin
								ph_q <= tle_pkg::PH_NORMAL;
								if (s_tdata == tle_pkg::KEY_TILDE && cur_q < len_q) begin
									idx_q   <= cur_q;
									state_q <= ST_DEL_RD;
								end else begin
									state_q <= ST_UPDATE;
								end
							end
							tle_pkg::PH_PAGE: begin
								ph_q    <= tle_pkg::PH_NORMAL;
								state_q <= ST_UPDATE;
							end
							default: begin
								ph_q <= tle_pkg::PH_NORMAL;
								priority if (s_tdata == tle_pkg::KEY_LF ||
								             s_tdata == tle_pkg::KEY_CR) begin
									nline_q <= len_q;
									state_q <= ST_ENT_SAVE;
								end else if (s_tdata == tle_pkg::KEY_BS) begin
									if (cur_q != '0) begin
										cur_q   <= cur_q - LW'(1);
										idx_q   <= cur_q - LW'(1);
										state_q <= ST_DEL_RD;
									end else begin
										state_q <= ST_UPDATE;
									end
								end else if (s_tdata == tle_pkg::KEY_ESC) begin
									ph_q <= tle_pkg::PH_ESC;
								end else if (s_tdata >= tle_pkg::KEY_SPACE &&
								             s_tdata < tle_pkg::KEY_DEL) begin
									browse_q  <= used_q;
									stash_v_q <= 1'b0;
									if (len_q < tle_pkg::LINE_MAX_L) begin
										idx_q   <= len_q;
										state_q <= ST_INS_RD;
									end else begin
										state_q <= ST_UPDATE;
									end
								end else begin
									state_q <= ST_IDLE;
								end
							end
						endcase
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_kind_q <= tle_pkg::KIND_UPDATE;
						out_char_q <= '0;
						out_len_q  <= len_q;
						out_cur_q  <= cur_q;
						out_last_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_INS_RD: begin
					state_q <= (idx_q == cur_q) ? ST_INS_PUT : ST_INS_WR;
				end
				ST_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= ST_INS_RD;
				end
				ST_INS_PUT: begin
					len_q   <= len_q + LW'(1);
					cur_q   <= cur_q + LW'(1);
					state_q <= ST_UPDATE;
				end
				ST_DEL_RD: begin
					if (idx_p1 >= len_q) begin
						len_q   <= len_q - LW'(1);
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_DEL_WR;
					end
				end
				ST_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= ST_DEL_RD;
				end
				ST_UP: begin
					if (browse_q == '0) begin
						state_q <= ST_UPDATE;
					end else begin
						browse_q <= b_dn;
						slot_q   <= oldest_q + b_dn[SW-1:0];
						if (browse_q == used_q && len_q != '0) begin
							stash_len_q <= len_q;
							stash_v_q   <= 1'b1;
							src_q       <= tle_pkg::MEM_EDIT;
							dst_q       <= tle_pkg::MEM_STASH;
							cnt_q       <= len_q;
							idx_q       <= '0;
							post_q      <= tle_pkg::POST_LOAD;
							state_q     <= ST_COPY_RD;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DOWN: begin
					if (browse_q >= used_q) begin
						state_q <= ST_UPDATE;
					end else begin
						browse_q <= b_up;
						slot_q   <= oldest_q + b_up[SW-1:0];
						if (b_up == used_q) begin
							if (stash_v_q) begin
								src_q   <= tle_pkg::MEM_STASH;
								dst_q   <= tle_pkg::MEM_EDIT;
								cnt_q   <= stash_len_q;
								idx_q   <= '0;
								post_q  <= tle_pkg::POST_SETLEN;
								state_q <= ST_COPY_RD;
							end else begin
								len_q   <= '0;
								cur_q   <= '0;
								state_q <= ST_UPDATE;
							end
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					src_q   <= tle_pkg::MEM_HIST;
					dst_q   <= tle_pkg::MEM_EDIT;
					cnt_q   <= hlen_q[slot_q];
					idx_q   <= '0;
					post_q  <= tle_pkg::POST_SETLEN;
					state_q <= ST_COPY_RD;
				end
				ST_COPY_RD: begin
					if (idx_q == cnt_q) begin
						unique case (post_q)
							tle_pkg::POST_LOAD: state_q <= ST_LOAD;
							tle_pkg::POST_EMIT: state_q <= ST_EMIT_PREP;
							default: begin
								len_q   <= cnt_q;
								cur_q   <= cnt_q;
								state_q <= ST_UPDATE;
							end
						endcase
					end else begin
						state_q <= ST_COPY_WR;
					end
				end
				ST_COPY_WR: begin
					idx_q   <= idx_p1;
					state_q <= ST_COPY_RD;
				end
				ST_ENT_SAVE: begin
					idx_q <= '0;
					if (len_q == '0) begin
						state_q <= ST_EMIT_PREP;
					end else if (used_q != '0 &&
					             hlen_q[oldest_q + SW'(used_q - UW'(1))] == len_q) begin
						slot_q  <= oldest_q + SW'(used_q - UW'(1));
						cnt_q   <= len_q;
						state_q <= ST_CMP_RD;
					end else begin
						state_q <= ST_ENT_STORE;
					end
				end
				ST_CMP_RD: begin
					state_q <= (idx_q == cnt_q) ? ST_EMIT_PREP : ST_CMP_CHK;
				end
				ST_CMP_CHK: begin
					if (edit_rdata != hist_rdata) begin
						state_q <= ST_ENT_STORE;
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_CMP_RD;
					end
				end
				ST_ENT_STORE: begin
					if (used_q < tle_pkg::HIST_FULL) begin
						slot_q <= oldest_q + used_q[SW-1:0];
						hlen_q[oldest_q + used_q[SW-1:0]] <= len_q;
						used_q <= used_q + UW'(1);
					end else begin
						slot_q   <= oldest_q;
						hlen_q[oldest_q] <= len_q;
						oldest_q <= oldest_q + SW'(1);
					end
					src_q   <= tle_pkg::MEM_EDIT;
					dst_q   <= tle_pkg::MEM_HIST;
					cnt_q   <= len_q;
					idx_q   <= '0;
					post_q  <= tle_pkg::POST_EMIT;
					state_q <= ST_COPY_RD;
				end
				ST_EMIT_PREP: begin
					len_q     <= '0;
					cur_q     <= '0;
					browse_q  <= used_q;
					stash_v_q <= 1'b0;
					idx_q     <= '0;
					if (nline_q == '0) begin
						if (out_free) begin
							out_v_q    <= 1'b1;
							out_kind_q <= tle_pkg::KIND_EMPTY;
							out_char_q <= '0;
							out_len_q  <= '0;
							out_cur_q  <= '0;
							out_last_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end else begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_kind_q <= tle_pkg::KIND_CHAR;
						out_char_q <= edit_rdata;
						out_len_q  <= '0;
						out_cur_q  <= '0;
						out_last_q <= (idx_p1 == nline_q);
						idx_q      <= idx_p1;
						state_q    <= (idx_p1 == nline_q) ? ST_IDLE : ST_EMIT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
